// ----- hdl/acf_pkg.sv -----
// Package for the autocorrelation pitch detector: widths, register indexes and types.
// No dependencies; acf_if, acf_div and the top level import it.
`timescale 1ns / 1ps
package acf_pkg;
  localparam int FrameDepth = 1024;
  localparam int AddrW      = $clog2(FrameDepth);
  localparam int CountW     = AddrW + 1;
  localparam int SampleW    = 16;
  localparam int AccW       = 48;
  localparam int RateW      = 18;
  localparam int MmsW       = 31;
  localparam int TrimW      = 15;
  localparam int FreqW      = 24;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 32;

  localparam logic [CfgIdxW-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_MS      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TRIM        = 2'd2;

  localparam logic [FreqW-1:0] FreqMax = {FreqW{1'b1}};

  // Divider request/response between the sequencer and the shared divider
  typedef struct packed {
    logic          start;
    logic [63:0]   num;
    logic [63:0]   den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [63:0]   quo;
  } div_rsp_t;
endpackage

// ----- hdl/acf_if.sv -----
// Valid/ready channel interfaces for samples, results and configuration writes.
// Depends on acf_pkg.
`timescale 1ns / 1ps
interface acf_in_if;
  import acf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic                      last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface acf_out_if;
  import acf_pkg::*;
  logic             valid;
  logic             ready;
  logic             pitch_found;
  logic [FreqW-1:0] frequency_q8;
  modport source (output valid, pitch_found, frequency_q8, input ready);
  modport sink   (input valid, pitch_found, frequency_q8, output ready);
endinterface

interface acf_cfg_if;
  import acf_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/acf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module acf_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/acf_div.sv -----
// Shared restoring divider, one quotient bit per cycle, unsigned 64/64.
// Depends on acf_pkg.
`timescale 1ns / 1ps
module acf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  acf_pkg::div_req_t req,
  output acf_pkg::div_rsp_t rsp
);
  import acf_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [63:0] q_r;
  logic [63:0] d_r;
  logic [64:0] rem_r;
  logic [64:0] trial;

  assign trial = {rem_r[63:0], q_r[63]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
        q_r    <= req.num;
        d_r    <= req.den;
        rem_r  <= '0;
      end else if (busy_r) begin
        // shift in one numerator bit, subtract when it fits
        if (!trial[64]) begin
          rem_r <= trial;
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[63:0], q_r[63]};
          q_r   <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> $past(busy_r)) else $error("done without work");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> !busy_r) else $error("busy after done");
`endif
endmodule

// ----- hdl/autocorrelation_pitch_detector_top.sv -----
// Top level of the autocorrelation pitch detector: sequencer, shared MAC, stores.
// Depends on acf_pkg, acf_if, acf_ram and acf_div.
`timescale 1ns / 1ps
// Usage:
//   in  : one Q1.15 sample per request, last_sample closes the frame.
//   out : one result per frame (pitch_found, frequency_q8 in Q.8 Hz).
//   cfg : register writes (0 sample_rate, 1 min_mean_square, 2 trim_threshold),
//         only while the block is idle; taken in any cycle.
// Timing:
//   A non-last sample is accepted while the block is loading. The last sample starts the
//   analysis: trimming, then each lag-sum product read, multiplied and accumulated in turn
//   on the shared multiply-accumulate path, then dip and peak search and up to two divides.
//   The analysis time is set by the multiply-accumulate path reading the sample RAM.
//   in.ready is low from the last sample until the result is taken.
// Reset: registers return to 48000 / 1074 / 6554, count and energy clear.
//   The stores need no clearing pass.
// Stall: the result holds on out until out.ready; no new frame starts.
module autocorrelation_pitch_detector_top (
  input logic      clk,
  input logic      rst_n,
  acf_in_if.sink   in_ch,
  acf_out_if.source out_ch,
  acf_cfg_if.sink  cfg_ch
);
  import acf_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD, S_CHK, S_T1A, S_T1B, S_T2A, S_T2B, S_LAGI, S_MA, S_MB, S_MC,
    S_MD, S_LAGW, S_DA, S_DB, S_DC, S_PA, S_PB, S_XA, S_XB, S_XC, S_XD,
    S_DIV1, S_DIV2, S_OUT
  } state_t;

  state_t state_r;
  logic [RateW-1:0]  rate_r;
  logic [MmsW-1:0]   mms_r;
  logic [TrimW-1:0]  trim_r;
  logic [CountW-1:0] cnt_r, size_r, i_r, j_r, r1_r, r2_r, n_r, d_r, pos_r;
  logic [AccW-1:0]   energy_r, acc_r, prev_r, maxv_r, x1_r, x2_r;
  logic signed [SampleW-1:0] a_r;
  logic signed [31:0] prod_r;
  logic              found_r, has_max_r;
  logic [FreqW-1:0]  freq_r;
  logic signed [63:0] period_r;
  logic              neg_r;
  logic [63:0]       den_r;

  // sample store and lag sums
  logic              s_we, l_we;
  logic [AddrW-1:0]  s_wa, s_ra, l_wa, l_ra;
  logic [SampleW-1:0] s_rd;
  logic [AccW-1:0]   l_rd;
  div_req_t          dreq;
  div_rsp_t          drsp;

  acf_ram #(.Width(SampleW), .Depth(FrameDepth)) u_smp (
    .clk, .we(s_we), .waddr(s_wa), .wdata(in_ch.sample), .raddr(s_ra), .rdata(s_rd));
  acf_ram #(.Width(AccW), .Depth(FrameDepth)) u_lag (
    .clk, .we(l_we), .waddr(l_wa), .wdata(acc_r), .raddr(l_ra), .rdata(l_rd));
  acf_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  logic in_acc;
  assign in_ch.ready  = (state_r == S_LOAD);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.pitch_found  = found_r;
  assign out_ch.frequency_q8 = freq_r;

  assign s_we = in_acc && (cnt_r < CountW'(FrameDepth));
  assign s_wa = cnt_r[AddrW-1:0];
  assign l_we = (state_r == S_LAGW);
  assign l_wa = i_r[AddrW-1:0];

  logic [SampleW:0]  smag;
  logic signed [AccW-1:0] ls, pv, mx;
  logic [CountW-1:0] half;
  logic [63:0]       mms_n;
  assign smag = s_rd[SampleW-1] ? (SampleW+1)'(-$signed({s_rd[SampleW-1], s_rd}))
                                : {1'b0, s_rd};
  assign ls   = $signed(l_rd);
  assign pv   = $signed(prev_r);
  assign mx   = $signed(maxv_r);
  assign half = size_r >> 1;
  assign mms_n = 64'(mms_r) * 64'(size_r);

  // read address mux
  always_comb begin
    s_ra = '0;
    l_ra = '0;
    case (state_r)
      S_T1A:  s_ra = i_r[AddrW-1:0];
      S_T2A:  s_ra = AddrW'(size_r - i_r);
      S_MA:   s_ra = AddrW'(r1_r + j_r);
      S_MB:   s_ra = AddrW'(r1_r + j_r + i_r);
      S_DA, S_PA: l_ra = i_r[AddrW-1:0];
      S_XA:   l_ra = AddrW'(pos_r - 1'b1);
      S_XB:   l_ra = pos_r[AddrW-1:0];
      S_XC:   l_ra = AddrW'(pos_r + 1'b1);
      default: ;
    endcase
  end

  logic signed [AccW+1:0] dsum, dnum;
  assign dsum = 2 * ($signed({{2{x1_r[AccW-1]}}, x1_r}) + $signed({{2{l_rd[AccW-1]}}, l_rd})
                - 2 * $signed({{2{x2_r[AccW-1]}}, x2_r}));
  assign dnum = $signed({{2{l_rd[AccW-1]}}, l_rd}) - $signed({{2{x1_r[AccW-1]}}, x1_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      rate_r   <= RateW'(48000);
      mms_r    <= MmsW'(1074);
      trim_r   <= TrimW'(6554);
      cnt_r    <= '0;
      energy_r <= '0;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_SAMPLE_RATE: rate_r <= cfg_ch.data[RateW-1:0];
          REG_MIN_MS:      mms_r  <= cfg_ch.data[MmsW-1:0];
          REG_TRIM:        trim_r <= cfg_ch.data[TrimW-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_LOAD: if (in_acc) begin
          if (cnt_r < CountW'(FrameDepth)) begin
            cnt_r    <= cnt_r + 1'b1;
            energy_r <= energy_r + AccW'($unsigned(32'(in_ch.sample * in_ch.sample)));
          end
          if (in_ch.last_sample) begin
            size_r <= (cnt_r < CountW'(FrameDepth)) ? cnt_r + 1'b1 : cnt_r;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          cnt_r <= '0;
          energy_r <= '0;
          found_r <= 1'b0;
          freq_r  <= '0;
          r1_r <= '0;
          r2_r <= size_r - 1'b1;
          i_r  <= '0;
          if (64'(energy_r) < mms_n) state_r <= S_OUT;
          else state_r <= S_T1A;
        end
        // front trim scan
        S_T1A: state_r <= (i_r < half) ? S_T1B : S_T2A;
        S_T1B: begin
          if (smag < (SampleW+1)'(trim_r)) begin
            r1_r <= i_r; i_r <= CountW'(1); state_r <= S_T2A;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= (i_r + 1'b1 < half) ? S_T1A : S_T2A;
            if (!(i_r + 1'b1 < half)) i_r <= CountW'(1);
          end
        end
        // back trim scan
        S_T2A: state_r <= (i_r < half) ? S_T2B : S_LAGI;
        S_T2B: begin
          if (smag < (SampleW+1)'(trim_r)) begin
            r2_r <= size_r - i_r; state_r <= S_LAGI;
          end else begin
            i_r <= i_r + 1'b1; state_r <= S_T2A;
          end
        end
        S_LAGI: begin
          n_r <= r2_r - r1_r;
          i_r <= '0; j_r <= '0; acc_r <= '0;
          if ($signed({1'b0, r2_r}) - $signed({1'b0, r1_r}) < 2) state_r <= S_OUT;
          else state_r <= S_MA;
        end
        // shared MAC over j for lag i
        S_MA: state_r <= (j_r < n_r - i_r) ? S_MB : S_LAGW;
        S_MB: begin a_r <= s_rd; state_r <= S_MC; end
        S_MC: begin prod_r <= a_r * $signed(s_rd); state_r <= S_MD; end
        S_MD: begin
          acc_r <= acc_r + AccW'(prod_r);
          j_r <= j_r + 1'b1;
          state_r <= S_MA;
        end
        S_LAGW: begin
          acc_r <= '0; j_r <= '0; i_r <= i_r + 1'b1;
          if (i_r + 1'b1 < n_r) state_r <= S_MA;
          else begin i_r <= '0; d_r <= '0; state_r <= S_DA; end
        end
        // skip to first dip: compare consecutive lag sums
        S_DA: state_r <= S_DB;
        S_DB: begin
          if (i_r == '0) begin
            prev_r <= l_rd; i_r <= CountW'(1);
            state_r <= (n_r > CountW'(1)) ? S_DA : S_DC;
          end else if (pv > ls) begin
            prev_r <= l_rd; d_r <= i_r;
            if (i_r + 1'b1 < n_r) begin i_r <= i_r + 1'b1; state_r <= S_DA; end
            else begin d_r <= i_r; state_r <= S_DC; end
          end else state_r <= S_DC;
        end
        S_DC: begin
          i_r <= d_r; maxv_r <= {{(AccW-31){1'b1}}, 31'h40000000};
          has_max_r <= 1'b0; state_r <= S_PA;
        end
        // peak search
        S_PA: state_r <= S_PB;
        S_PB: begin
          if (ls > mx) begin maxv_r <= l_rd; pos_r <= i_r; has_max_r <= 1'b1; end
          if (i_r + 1'b1 < n_r) begin i_r <= i_r + 1'b1; state_r <= S_PA; end
          else state_r <= S_XA;
        end
        // neighbor fetch and interpolation
        S_XA: begin
          if (!has_max_r || pos_r < CountW'(1) || pos_r >= n_r - 1'b1) state_r <= S_OUT;
          else state_r <= S_XB;
        end
        S_XB: begin x1_r <= l_rd; state_r <= S_XC; end
        S_XC: begin x2_r <= l_rd; state_r <= S_XD; end
        S_XD: begin
          period_r <= 64'(pos_r) <<< 8;
          if (dsum == '0) begin
            neg_r <= 1'b0; den_r <= '0; state_r <= S_DIV2;
            dreq.start <= 1'b0;
          end else begin
            neg_r <= (dnum < 0) != (dsum < 0);
            den_r <= 64'(dsum < 0 ? -dsum : dsum);
            dreq.num <= (64'(dnum < 0 ? -dnum : dnum) << 8)
                        + (64'(dsum < 0 ? -dsum : dsum) >> 1);
            dreq.den <= 64'(dsum < 0 ? -dsum : dsum);
            dreq.start <= 1'b1;
            state_r <= S_DIV1;
          end
        end
        S_DIV1: if (drsp.done) begin
          period_r <= neg_r ? period_r + $signed(drsp.quo) : period_r - $signed(drsp.quo);
          state_r <= S_DIV2;
          den_r <= '0;
        end
        S_DIV2: begin
          if (den_r == '0 && !dreq.start && !(period_r > 0)) state_r <= S_OUT;
          else if (den_r == '0 && !dreq.start) begin
            dreq.num <= ({46'd0, rate_r} << 16) + (64'(period_r) >> 1);
            dreq.den <= 64'(period_r);
            dreq.start <= 1'b1;
            den_r <= 64'd1;
          end else if (drsp.done) begin
            found_r <= 1'b1;
            freq_r <= (drsp.quo > 64'(FreqMax)) ? FreqMax : drsp.quo[FreqW-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: if (out_ch.ready) state_r <= S_LOAD;
        default: state_r <= S_LOAD;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> !in_ch.ready) else $error("input taken while busy");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready) |=> !out_ch.valid) else $error("result repeated");
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |=> (cnt_r == '0)) else $error("count not cleared");
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.pitch_found) |-> (out_ch.frequency_q8 == '0))
    else $error("rejected frame has frequency");
`endif
endmodule
